FILE: rtl/gbalu_pkg.sv
// shared types, operation codes and shift kinds of the game boy cpu alu
`timescale 1ns / 1ps

package gbalu_pkg;

	// func codes of an incoming command
	localparam logic [4:0] FUNC_ADD  = 5'd0;
	localparam logic [4:0] FUNC_ADC  = 5'd1;
	localparam logic [4:0] FUNC_SUB  = 5'd2;
	localparam logic [4:0] FUNC_SBC  = 5'd3;
	localparam logic [4:0] FUNC_AND  = 5'd4;
	localparam logic [4:0] FUNC_XOR  = 5'd5;
	localparam logic [4:0] FUNC_OR   = 5'd6;
	localparam logic [4:0] FUNC_CP   = 5'd7;
	localparam logic [4:0] FUNC_INC  = 5'd8;
	localparam logic [4:0] FUNC_DEC  = 5'd9;
	localparam logic [4:0] FUNC_DAA  = 5'd10;
	localparam logic [4:0] FUNC_CPL  = 5'd11;
	localparam logic [4:0] FUNC_SCF  = 5'd12;
	localparam logic [4:0] FUNC_CCF  = 5'd13;
	localparam logic [4:0] FUNC_RLCA = 5'd14;
	localparam logic [4:0] FUNC_RRCA = 5'd15;
	localparam logic [4:0] FUNC_RLA  = 5'd16;
	localparam logic [4:0] FUNC_RRA  = 5'd17;
	localparam logic [4:0] FUNC_CB   = 5'd18;

	// cb opcode groups, bits 7..6
	localparam logic [1:0] CB_SHIFT = 2'd0;
	localparam logic [1:0] CB_BIT   = 2'd1;
	localparam logic [1:0] CB_RES   = 2'd2;
	localparam logic [1:0] CB_SET   = 2'd3;

	// shift and rotate kinds, shared by the a rotates and the cb shifts
	localparam logic [2:0] SH_RLC  = 3'd0;
	localparam logic [2:0] SH_RRC  = 3'd1;
	localparam logic [2:0] SH_RL   = 3'd2;
	localparam logic [2:0] SH_RR   = 3'd3;
	localparam logic [2:0] SH_SLA  = 3'd4;
	localparam logic [2:0] SH_SRA  = 3'd5;
	localparam logic [2:0] SH_SWAP = 3'd6;
	localparam logic [2:0] SH_SRL  = 3'd7;

	// flag bit positions
	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	// daa constants
	localparam logic [7:0] DAA_LIMIT = 8'h99;
	localparam logic [7:0] DAA_HI    = 8'h60;
	localparam logic [7:0] DAA_LO    = 8'h06;
	localparam logic [3:0] DAA_NIB   = 4'd9;

	typedef enum logic [4:0] {
		OP_ADD, OP_SUB, OP_CP, OP_AND, OP_XOR, OP_OR, OP_INC, OP_DEC,
		OP_DAA, OP_CPL, OP_SCF, OP_CCF, OP_ROTA, OP_CBSH, OP_BIT,
		OP_RES, OP_SET, OP_NOP
	} op_t;

	typedef struct packed {
		logic [4:0] func;
		logic [7:0] value_a;
		logic [7:0] operand;
		logic [3:0] flags_in;
	} cmd_t;

	typedef struct packed {
		logic [7:0] result;
		logic       write_back;
		logic [3:0] flags_out;
	} rsp_t;

	// decoded operation: adder inputs already prepared
	typedef struct packed {
		op_t        op;
		logic [7:0] a;
		logic [7:0] b;
		logic       cin;
		logic [3:0] fl;
		logic [2:0] idx;
		logic       daa_c;
	} dec_t;

	// raw execution result before flag forming
	typedef struct packed {
		op_t        op;
		logic [7:0] a;
		logic [7:0] val;
		logic       c;
		logic       h;
		logic [3:0] fl;
		logic       daa_c;
	} exe_t;

endpackage

FILE: rtl/gameboy_cpu_alu_unit.sv
// top level of the game boy cpu alu: three-stage pipeline
`timescale 1ns / 1ps

// 8-bit alu of the game boy cpu: a command transferred at a rising edge (start high,
// busy low) passes the decode, execute and flag registers in that order; done then
// rises and stays high for exactly one cycle, and the result is taken at the edge
// that ends it. a new command may be transferred at every edge, so up to three
// are in flight; the pipeline has no stall path, busy is always low and results
// leave in command order. the receiver cannot hold results off and must take
// each one in its done cycle.
// the three stages are decode (operation class, adder operands, daa
// correction), execute (nibble-split adder, logic, shifter, bit masks) and
// flag forming with the write-back select, each closed by a register.
// commands with an undefined func code return value_a, write_back low and
// the flags unchanged.

module gameboy_cpu_alu_unit import gbalu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output rsp_t rsp
);

	logic in_valid;
	logic v_s1;
	logic v_s2;
	dec_t dec_s1;
	exe_t exe_s2;

	// never stalls: one command per cycle
	assign busy     = 1'b0;
	assign in_valid = start & ~busy;

	// decode
	gbalu_dec u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.in_valid(in_valid),
		.cmd    (cmd),
		.v_s1   (v_s1),
		.dec_s1 (dec_s1)
	);

	// execute
	gbalu_exe u_exe (
		.clk    (clk),
		.arst_n (arst_n),
		.v_s1   (v_s1),
		.dec_s1 (dec_s1),
		.v_s2   (v_s2),
		.exe_s2 (exe_s2)
	);

	// flags and output register, done is the stage valid
	gbalu_flg u_flg (
		.clk    (clk),
		.arst_n (arst_n),
		.v_s2   (v_s2),
		.exe_s2 (exe_s2),
		.v_s3   (done),
		.rsp_s3 (rsp)
	);

endmodule

FILE: rtl/gbalu_dec.sv
// stage one: command decode and adder operand preparation
`timescale 1ns / 1ps

module gbalu_dec import gbalu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  cmd_t cmd,
	output logic v_s1,
	output dec_t dec_s1
);

	dec_t d;
	logic fn;
	logic fh;
	logic fc;
	logic [7:0] adj;
	logic daa_c;

	assign fn = cmd.flags_in[FLAG_N];
	assign fh = cmd.flags_in[FLAG_H];
	assign fc = cmd.flags_in[FLAG_C];

	// daa correction
	always_comb begin
		adj   = 8'h00;
		daa_c = 1'b0;
		if (fh || (!fn && (cmd.value_a[3:0] > DAA_NIB)))
			adj = DAA_LO;
		if (fc || (!fn && (cmd.value_a > DAA_LIMIT))) begin
			adj   = adj | DAA_HI;
			daa_c = 1'b1;
		end
	end

	always_comb begin
		d.op    = OP_NOP;
		d.a     = cmd.value_a;
		d.b     = cmd.operand;
		d.cin   = 1'b0;
		d.fl    = cmd.flags_in;
		d.idx   = cmd.operand[5:3];
		d.daa_c = daa_c;
		case (cmd.func)
			FUNC_ADD: d.op = OP_ADD;
			FUNC_ADC: begin
				d.op  = OP_ADD;
				d.cin = fc;
			end
			// subtract as a plus inverted b plus inverted borrow
			FUNC_SUB: begin
				d.op  = OP_SUB;
				d.b   = ~cmd.operand;
				d.cin = 1'b1;
			end
			FUNC_SBC: begin
				d.op  = OP_SUB;
				d.b   = ~cmd.operand;
				d.cin = ~fc;
			end
			FUNC_CP: begin
				d.op  = OP_CP;
				d.b   = ~cmd.operand;
				d.cin = 1'b1;
			end
			FUNC_AND: d.op = OP_AND;
			FUNC_XOR: d.op = OP_XOR;
			FUNC_OR:  d.op = OP_OR;
			FUNC_INC: begin
				d.op  = OP_INC;
				d.b   = 8'h00;
				d.cin = 1'b1;
			end
			FUNC_DEC: begin
				d.op  = OP_DEC;
				d.b   = 8'hFF;
				d.cin = 1'b0;
			end
			FUNC_DAA: begin
				d.op  = OP_DAA;
				d.b   = fn ? ~adj : adj;
				d.cin = fn;
			end
			FUNC_CPL: d.op = OP_CPL;
			FUNC_SCF: d.op = OP_SCF;
			FUNC_CCF: d.op = OP_CCF;
			FUNC_RLCA: begin
				d.op  = OP_ROTA;
				d.idx = SH_RLC;
			end
			FUNC_RRCA: begin
				d.op  = OP_ROTA;
				d.idx = SH_RRC;
			end
			FUNC_RLA: begin
				d.op  = OP_ROTA;
				d.idx = SH_RL;
			end
			FUNC_RRA: begin
				d.op  = OP_ROTA;
				d.idx = SH_RR;
			end
			FUNC_CB: begin
				case (cmd.operand[7:6])
					CB_SHIFT: d.op = OP_CBSH;
					CB_BIT:   d.op = OP_BIT;
					CB_RES:   d.op = OP_RES;
					CB_SET:   d.op = OP_SET;
					default:  d.op = OP_NOP;
				endcase
			end
			default: d.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid)
			dec_s1 <= d;
	end

endmodule

FILE: rtl/gbalu_exe.sv
// stage two: nibble-split adder, logic ops, shifter and bit ops
`timescale 1ns / 1ps

module gbalu_exe import gbalu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic v_s1,
	input  dec_t dec_s1,
	output logic v_s2,
	output exe_t exe_s2
);

	logic [4:0] sum_lo;
	logic [4:0] sum_hi;
	logic [7:0] sum;
	logic [7:0] sh_r;
	logic       sh_c;
	logic [7:0] mask;
	logic [7:0] a;
	logic       fc;
	exe_t       e;

	assign a  = dec_s1.a;
	assign fc = dec_s1.fl[FLAG_C];

	assign sum_lo = {1'b0, a[3:0]} + {1'b0, dec_s1.b[3:0]} + {4'd0, dec_s1.cin};
	assign sum_hi = {1'b0, a[7:4]} + {1'b0, dec_s1.b[7:4]} + {4'd0, sum_lo[4]};
	assign sum    = {sum_hi[3:0], sum_lo[3:0]};
	assign mask   = 8'h01 << dec_s1.idx;

	always_comb begin
		sh_r = a;
		sh_c = 1'b0;
		case (dec_s1.idx)
			SH_RLC: begin
				sh_c = a[7];
				sh_r = {a[6:0], a[7]};
			end
			SH_RRC: begin
				sh_c = a[0];
				sh_r = {a[0], a[7:1]};
			end
			SH_RL: begin
				sh_c = a[7];
				sh_r = {a[6:0], fc};
			end
			SH_RR: begin
				sh_c = a[0];
				sh_r = {fc, a[7:1]};
			end
			SH_SLA: begin
				sh_c = a[7];
				sh_r = {a[6:0], 1'b0};
			end
			SH_SRA: begin
				sh_c = a[0];
				sh_r = {a[7], a[7:1]};
			end
			SH_SWAP: begin
				sh_c = 1'b0;
				sh_r = {a[3:0], a[7:4]};
			end
			SH_SRL: begin
				sh_c = a[0];
				sh_r = {1'b0, a[7:1]};
			end
			default: begin
				sh_c = 1'b0;
				sh_r = a;
			end
		endcase
	end

	always_comb begin
		e.op    = dec_s1.op;
		e.a     = a;
		e.fl    = dec_s1.fl;
		e.daa_c = dec_s1.daa_c;
		e.h     = sum_lo[4];
		e.c     = sum_hi[4];
		case (dec_s1.op)
			OP_ADD, OP_SUB, OP_CP, OP_INC, OP_DEC, OP_DAA: e.val = sum;
			OP_AND: e.val = a & dec_s1.b;
			OP_XOR: e.val = a ^ dec_s1.b;
			OP_OR:  e.val = a | dec_s1.b;
			OP_CPL: e.val = ~a;
			OP_ROTA, OP_CBSH: begin
				e.val = sh_r;
				e.c   = sh_c;
			end
			// tested bit alone, so zero detect gives the bit flag
			OP_BIT: e.val = a & mask;
			OP_RES: e.val = a & ~mask;
			OP_SET: e.val = a | mask;
			default: e.val = a;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (v_s1)
			exe_s2 <= e;
	end

endmodule

FILE: rtl/gbalu_flg.sv
// stage three: zero detect, flag forming, write-back select, output register
`timescale 1ns / 1ps

module gbalu_flg import gbalu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic v_s2,
	input  exe_t exe_s2,
	output logic v_s3,
	output rsp_t rsp_s3
);

	logic z;
	logic fz;
	logic fn;
	logic fc;
	logic wb;
	logic [3:0] f;
	rsp_t r;

	assign z  = (exe_s2.val == 8'h00);
	assign fz = exe_s2.fl[FLAG_Z];
	assign fn = exe_s2.fl[FLAG_N];
	assign fc = exe_s2.fl[FLAG_C];

	always_comb begin
		wb = 1'b1;
		f  = exe_s2.fl;
		case (exe_s2.op)
			OP_ADD:  f = {z, 1'b0, exe_s2.h, exe_s2.c};
			// carries of a + ~b are inverted borrows
			OP_SUB:  f = {z, 1'b1, ~exe_s2.h, ~exe_s2.c};
			OP_CP: begin
				f  = {z, 1'b1, ~exe_s2.h, ~exe_s2.c};
				wb = 1'b0;
			end
			OP_AND:  f = {z, 1'b0, 1'b1, 1'b0};
			OP_XOR:  f = {z, 3'b000};
			OP_OR:   f = {z, 3'b000};
			OP_INC:  f = {z, 1'b0, exe_s2.h, fc};
			OP_DEC:  f = {z, 1'b1, ~exe_s2.h, fc};
			OP_DAA:  f = {z, fn, 1'b0, exe_s2.daa_c};
			OP_CPL:  f = {fz, 1'b1, 1'b1, fc};
			OP_SCF: begin
				f  = {fz, 1'b0, 1'b0, 1'b1};
				wb = 1'b0;
			end
			OP_CCF: begin
				f  = {fz, 1'b0, 1'b0, ~fc};
				wb = 1'b0;
			end
			OP_ROTA: f = {3'b000, exe_s2.c};
			OP_CBSH: f = {z, 1'b0, 1'b0, exe_s2.c};
			OP_BIT: begin
				f  = {z, 1'b0, 1'b1, fc};
				wb = 1'b0;
			end
			OP_RES:  f = exe_s2.fl;
			OP_SET:  f = exe_s2.fl;
			default: begin
				f  = exe_s2.fl;
				wb = 1'b0;
			end
		endcase
		r.result     = wb ? exe_s2.val : exe_s2.a;
		r.write_back = wb;
		r.flags_out  = f;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (v_s2)
			rsp_s3 <= r;
	end

endmodule

FILE: rtl/gbalu_chk.sv
// port-level checker of the game boy cpu alu and its bind
`timescale 1ns / 1ps

module gbalu_chk import gbalu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input cmd_t cmd,
	input logic done,
	input rsp_t rsp
);

	// every transfer in gives a result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##2 done)
		else $error("missing result three cycles after transfer");

	// no result without a matching earlier transfer
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without matching transfer");

	// compare never writes back
	a_cp_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.func == FUNC_CP) |=> ##2 (done && !rsp.write_back))
		else $error("compare wrote back");

	// a result that is not written is the original register value
	a_keep_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.write_back) |-> rsp.result == $past(cmd.value_a, 3))
		else $error("unwritten result differs from value_a");

endmodule

bind gameboy_cpu_alu_unit gbalu_chk u_chk (.*);
